>>> rtl/rpfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpfp_pkg;

  localparam int unsigned WINDOW_BYTES = 8;
  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned CMDQ_DEPTH   = 4;

  localparam int unsigned CHAN_W = $clog2(CHANNELS);
  localparam int unsigned DUTY_W = 12;
  localparam int unsigned DEV_W  = 4;
  localparam int unsigned SUM_W  = 19;  // signed weighted digit sum

  localparam logic [7:0] STX_CODE   = 8'h02;
  localparam logic [7:0] ETX_CODE   = 8'h03;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ON    = 8'h6F;  // 'o'
  localparam logic [7:0] CHAR_WRITE = 8'h77;  // 'w'

  localparam logic [DUTY_W-1:0]       DUTY_MAX = 12'd2499;
  // (DUTY_MAX + 1) * 4: at or above this the quarter value saturates
  localparam logic signed [SUM_W-1:0] SUM_SAT  = 19'sd10000;

  typedef enum logic [1:0] {
    CMD_ON,
    CMD_OFF,
    CMD_WRITE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic [CHAN_W-1:0]         chan;
    logic signed [SUM_W-1:0]   sum;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/rpfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  wire [7:0]                rx_byte_i,
  input  wire                      cfg_we_i,
  input  wire [rpfp_pkg::DEV_W-1:0] cfg_data_i,
  output logic                     cmd_valid_o,
  output rpfp_pkg::cmd_t           cmd_o
);
  import rpfp_pkg::*;

  logic [7:0]       win_q [WINDOW_BYTES];
  logic [7:0]       win_d [WINDOW_BYTES];
  logic [DEV_W-1:0] dev_q;

  logic             is_switch, is_write, dev_ok, in_band;
  logic [DEV_W-1:0] dev_m1;
  logic [7:0]       offset, base, chan_byte, diff;
  logic signed [8:0] dig [4];

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WINDOW_BYTES-1] = rx_byte_i;

    is_switch = (win_d[4] == STX_CODE) && (win_d[7] == ETX_CODE);
    is_write  = !is_switch && (win_d[0] == STX_CODE) && (win_d[7] == ETX_CODE);

    // band check: channel byte minus band base must land in 0..3
    dev_m1    = dev_q - DEV_W'(1);
    dev_ok    = (dev_q >= DEV_W'(1)) && (dev_q <= DEV_W'(4));
    offset    = {2'b00, dev_m1, 2'b00};
    base      = DIGIT_ZERO + offset;
    chan_byte = is_switch ? win_d[5] : win_d[1];
    diff      = chan_byte - base;
    in_band   = dev_ok && (diff[7:2] == 6'd0);

    // rebase the channel byte in place; later frames see the new value
    if (is_switch && in_band) begin
      win_d[5] = chan_byte - offset;
    end else if (is_write && in_band) begin
      win_d[1] = chan_byte - offset;
    end

    for (int k = 0; k < 4; k++) begin
      dig[k] = $signed({1'b0, win_d[3+k]}) - $signed({1'b0, DIGIT_ZERO});
    end

    cmd_o.chan = diff[CHAN_W-1:0];
    cmd_o.sum  = SUM_W'(dig[0]) * 19'sd1000 + SUM_W'(dig[1]) * 19'sd100
               + SUM_W'(dig[2]) * 19'sd10 + SUM_W'(dig[3]);
    cmd_o.kind = is_switch ? ((win_d[6] == CHAR_ON) ? CMD_ON : CMD_OFF) : CMD_WRITE;
    cmd_valid_o = accept_i && in_band
                && (is_switch || (is_write && (win_d[2] == CHAR_WRITE)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_BYTES; i++) begin
        win_q[i] <= '0;
      end
      dev_q <= DEV_W'(1);
    end else begin
      if (accept_i) begin
        win_q <= win_d;
      end
      if (cfg_we_i) begin
        dev_q <= cfg_data_i;
      end
    end
  end

  // a command only leaves with an accepted byte of an in-range unit
  a_cmd_needs_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> (accept_i && dev_q != '0 && dev_q <= DEV_W'(4)))
    else $error("command without accepted byte or valid unit number");

endmodule

`default_nettype wire

>>> rtl/rpfp_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_cmd_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  rpfp_pkg::cmd_t data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           valid_o,
  output rpfp_pkg::cmd_t data_o
);
  import rpfp_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("command queue count did not follow a lone push");

endmodule

`default_nettype wire

>>> rtl/rpfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rpfp_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cmd_valid_i,
  input  rpfp_pkg::cmd_t              cmd_i,
  output logic                        cmd_take_o,
  input  wire                         pop_i,
  output logic                        out_valid_o,
  output logic [rpfp_pkg::CHAN_W-1:0] channel_o,
  output logic [rpfp_pkg::DUTY_W-1:0] duty_o,
  output logic                        channel_on_o
);
  import rpfp_pkg::*;

  logic [DUTY_W-1:0] duty_q [CHANNELS];
  logic [CHANNELS-1:0] on_q;
  logic              out_valid_q;
  logic [CHAN_W-1:0] chan_q;
  logic [DUTY_W-1:0] duty_out_q, duty_d, sat_duty;
  logic              on_out_q, on_d;

  // result slot frees when empty or popped this cycle
  assign cmd_take_o = cmd_valid_i && (!out_valid_q || pop_i);

  // sum / 4 truncated, clamped to 0..DUTY_MAX
  always_comb begin
    if (cmd_i.sum < 0) begin
      sat_duty = '0;
    end else if (cmd_i.sum >= SUM_SAT) begin
      sat_duty = DUTY_MAX;
    end else begin
      sat_duty = cmd_i.sum[DUTY_W+1:2];
    end
  end

  always_comb begin
    unique case (cmd_i.kind)
      CMD_ON: begin
        duty_d = duty_q[cmd_i.chan];
        on_d   = 1'b1;
      end
      CMD_OFF: begin
        duty_d = '0;
        on_d   = 1'b0;
      end
      CMD_WRITE: begin
        duty_d = sat_duty;
        on_d   = on_q[cmd_i.chan];
      end
      default: begin
        duty_d = '0;
        on_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      on_q        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        duty_q[i] <= '0;
      end
    end else begin
      if (cmd_take_o) begin
        out_valid_q <= 1'b1;
        if (cmd_i.kind == CMD_WRITE) begin
          duty_q[cmd_i.chan] <= sat_duty;
        end else begin
          on_q[cmd_i.chan] <= on_d;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      chan_q     <= cmd_i.chan;
      duty_out_q <= duty_d;
      on_out_q   <= on_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign channel_o    = chan_q;
  assign duty_o       = duty_out_q;
  assign channel_on_o = on_out_q;

  a_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_take_o && cmd_i.kind == CMD_ON) |=> (channel_on_o && on_q[channel_o]))
    else $error("switch-on result or flag missing");

endmodule

`default_nettype wire

>>> rtl/remote_pwm_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// input     in   push / full            rx_byte_i[7:0]
// result    out  empty / pop            channel_o[1:0], duty_o[11:0], channel_on_o
// config    in   cfg_valid_i/cfg_ready_o cfg_data_i[3:0] (device number)
//
// One word per cycle in while full is low; a frame's command enters the
// command queue at the edge that accepts its last byte (the front classifies
// combinationally), and the back registers the result when it takes the command.
// The front shifts the byte window and classifies frames in the accept cycle;
// the back applies switch / write commands to the per-channel duty and flags.
// A 4-entry command queue decouples them: full rises only when the queue
// fills while results are not being popped. Reset clears the window, duty
// and flag stores and sets the device number to 1; config is always ready.

module remote_pwm_frame_parser_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push,
  output logic                               full,
  input  wire [7:0]                          rx_byte_i,
  output logic                               empty,
  input  wire                                pop,
  output logic [rpfp_pkg::CHAN_W-1:0]        channel_o,
  output logic [rpfp_pkg::DUTY_W-1:0]        duty_o,
  output logic                               channel_on_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [rpfp_pkg::DEV_W-1:0]          cfg_data_i
);
  import rpfp_pkg::*;

  logic accept, cmd_push, cmd_valid, cmd_take, out_valid;
  cmd_t cmd_front, cmd_queued;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  rpfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_front)
  );

  rpfp_cmd_fifo u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_front),
    .full_o  (full),
    .pop_i   (cmd_take),
    .valid_o (cmd_valid),
    .data_o  (cmd_queued)
  );

  rpfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_queued),
    .cmd_take_o   (cmd_take),
    .pop_i        (pop && !empty),
    .out_valid_o  (out_valid),
    .channel_o    (channel_o),
    .duty_o       (duty_o),
    .channel_on_o (channel_on_o)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire
